// ----- hw/rtl/palette_pixel_expander_top_defines.svh -----
// Assertion macros shared by the palette pixel expander RTL.
// In synthesis builds the macros expand to nothing.
`ifndef PALETTE_PIXEL_EXPANDER_TOP_DEFINES_SVH
`define PALETTE_PIXEL_EXPANDER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PPE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("palette pixel expander assertion failed");
// Condition that must never be true outside reset.
`define PPE_ASSERT_NEVER(label, clk, rst, cond) \
   `PPE_ASSERT(label, clk, rst, !(cond))
`else
`define PPE_ASSERT(label, clk, rst, prop)
`define PPE_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- hw/rtl/ppe_pkg.sv -----
package ppe_pkg;

   // Default palette size and depth of the result queue.
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int OUT_FIFO_DEPTH_DEFAULT = 4;

   // Item opcodes.
   localparam logic [1:0] OP_PALETTE_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_BPP_LOG2 = 1'b0;
   localparam logic CSR_IMAGE_PIXELS = 1'b1;

   // Bits-per-pixel codes.
   localparam logic [1:0] BPP_1 = 2'd0;
   localparam logic [1:0] BPP_2 = 2'd1;
   localparam logic [1:0] BPP_4 = 2'd2;
   localparam logic [1:0] BPP_8 = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] packed_byte;
   } req_item_type;

   typedef struct packed {
      logic [15:0] pixel_word;
      logic        last_of_byte;
      logic        end_of_image;
   } rsp_item_type;

   // Sideband that travels with a palette read to the output stage.
   typedef struct packed {
      logic valid;
      logic out_of_range;
      logic last_of_byte;
      logic end_of_image;
   } lookup_tag_type;

   // RGB888 to RGB565, keeping the top bits, with the two bytes swapped.
   function automatic logic [15:0] to_display_word(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
      logic [15:0] w;
      w = {r[7:3], g[7:2], b[7:3]};
      return {w[7:0], w[15:8]};
   endfunction

   // Lowest pixel field of a packed byte.
   function automatic logic [7:0] field_of(input logic [7:0] data, input logic [1:0] bpp);
      logic [7:0] f;
      case (bpp)
         BPP_1:   f = {7'd0, data[0]};
         BPP_2:   f = {6'd0, data[1:0]};
         BPP_4:   f = {4'd0, data[3:0]};
         default: f = data;
      endcase
      return f;
   endfunction

   // Drops the lowest pixel field of a packed byte.
   function automatic logic [7:0] shift_field(input logic [7:0] data, input logic [1:0] bpp);
      logic [7:0] s;
      case (bpp)
         BPP_1:   s = data >> 1;
         BPP_2:   s = data >> 2;
         BPP_4:   s = data >> 4;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

   // Number of pixel fields in one byte.
   function automatic logic [3:0] fields_in_byte(input logic [1:0] bpp);
      logic [3:0] n;
      case (bpp)
         BPP_1:   n = 4'd8;
         BPP_2:   n = 4'd4;
         BPP_4:   n = 4'd2;
         default: n = 4'd1;
      endcase
      return n;
   endfunction

endpackage

// ----- hw/rtl/ppe_palette_ram.sv -----
module ppe_palette_ram import ppe_pkg::*; #(
   parameter int DEPTH = PALETTE_DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // Write port. A read of the same entry in the same cycle sees the old value.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ppe_out_fifo.sv -----
module ppe_out_fifo import ppe_pkg::*; #(
   parameter int DEPTH = OUT_FIFO_DEPTH_DEFAULT,
   localparam int PW = $clog2(DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic [PW:0]  count,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type  slots [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          pop;

   // Pointer and fill count update.
   always_comb begin
      pop = (count_ff != '0) && rsp_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

   assign count = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item = slots[rd_ptr_ff];

endmodule

// ----- hw/rtl/palette_pixel_expander_top.sv -----
// Palette write and start items take effect in the cycle after they are accepted.
// A pixel byte's results pass through the byte register, the palette read register and the result queue.
// Throughput is one pixel word per cycle while the result queue has room, set by the single
// palette read port: a byte gives up to 8, 4, 2 or 1 words at 1, 2, 4 or 8 bits per pixel.
// Synchronous reset clears the counters, configuration registers and result queue; the
// palette is not cleared and an entry is undefined until it is written.
`include "palette_pixel_expander_top_defines.svh"

module palette_pixel_expander_top import ppe_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int OUT_DEPTH = OUT_FIFO_DEPTH_DEFAULT;
   localparam int FCW = $clog2(OUT_DEPTH) + 1;

   // Configuration registers.
   logic [1:0]  bpp_log2_ff, bpp_log2_in;
   logic [23:0] image_pixels_ff, image_pixels_in;

   // Expander state.
   logic [23:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  cur_bpp_ff, cur_bpp_in;
   logic [3:0]  left_ff, left_in;
   logic        eoi_ff, eoi_in;

   // Lookup stage.
   lookup_tag_type tag_ff, tag_in;

   logic           req_fire;
   logic           csr_fire;
   logic           busy;
   logic           room;
   logic           issue;
   logic [7:0]     field;
   logic [3:0]     per_byte;
   logic [3:0]     n_pixels;
   logic           pal_wr_en;
   logic [15:0]    pal_rd_data;
   logic [FCW-1:0] fifo_count;
   rsp_item_type   push_item;

   // Handshakes and issue control. A new item enters while the last field of
   // the current byte is read, so palette writes stay ordered after it.
   always_comb begin
      csr_ready = 1'b1;
      csr_fire = csr_valid && csr_ready;
      busy = (left_ff != 4'd0);
      room = (fifo_count + FCW'(tag_ff.valid)) <= FCW'(OUT_DEPTH - 2);
      issue = busy && room;
      req_ready = !busy || (issue && (left_ff == 4'd1));
      req_fire = req_valid && req_ready;
      field = field_of(byte_ff, cur_bpp_ff);
      per_byte = fields_in_byte(bpp_log2_ff);
      n_pixels = (pixels_left_ff < {20'd0, per_byte}) ? pixels_left_ff[3:0] : per_byte;
      pal_wr_en = req_fire && (req_item.opcode == OP_PALETTE_WRITE) &&
                  ({1'b0, req_item.entry_index} < 9'(PALETTE_DEPTH));
   end

   // Configuration writes.
   always_comb begin
      bpp_log2_in = bpp_log2_ff;
      image_pixels_in = image_pixels_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_BPP_LOG2:     bpp_log2_in = csr_wdata[1:0];
            CSR_IMAGE_PIXELS: image_pixels_in = csr_wdata;
         endcase
      end
   end

   // Item decode and field stepping. The pixel count is charged for the
   // whole byte when it is accepted.
   always_comb begin
      pixels_left_in = pixels_left_ff;
      byte_in = byte_ff;
      cur_bpp_in = cur_bpp_ff;
      left_in = left_ff;
      eoi_in = eoi_ff;
      if (issue) begin
         left_in = left_ff - 4'd1;
         byte_in = shift_field(byte_ff, cur_bpp_ff);
      end
      if (req_fire) begin
         unique case (req_item.opcode)
            OP_START: pixels_left_in = image_pixels_ff;
            OP_PIXEL: begin
               left_in = n_pixels;
               byte_in = req_item.packed_byte;
               cur_bpp_in = bpp_log2_ff;
               pixels_left_in = pixels_left_ff - {20'd0, n_pixels};
               eoi_in = (pixels_left_ff <= {20'd0, per_byte});
            end
            default: ;
         endcase
      end
   end

   // Sideband for the palette read in flight.
   always_comb begin
      tag_in.valid = issue;
      tag_in.out_of_range = ({1'b0, field} >= 9'(PALETTE_DEPTH));
      tag_in.last_of_byte = (left_ff == 4'd1);
      tag_in.end_of_image = eoi_ff && (left_ff == 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_log2_ff <= '0;
         image_pixels_ff <= '0;
         pixels_left_ff <= '0;
         left_ff <= '0;
         tag_ff <= '0;
      end else begin
         bpp_log2_ff <= bpp_log2_in;
         image_pixels_ff <= image_pixels_in;
         pixels_left_ff <= pixels_left_in;
         left_ff <= left_in;
         tag_ff <= tag_in;
      end
   end

   // Payload of the current byte.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      cur_bpp_ff <= cur_bpp_in;
      eoi_ff <= eoi_in;
   end

   ppe_palette_ram #(
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pal_wr_en),
      .wr_addr(req_item.entry_index[AW-1:0]),
      .wr_data(to_display_word(req_item.red, req_item.green, req_item.blue)),
      .rd_en  (issue),
      .rd_addr(field[AW-1:0]),
      .rd_data(pal_rd_data)
   );

   // Result assembly after the palette read.
   always_comb begin
      push_item.pixel_word = tag_ff.out_of_range ? 16'd0 : pal_rd_data;
      push_item.last_of_byte = tag_ff.last_of_byte;
      push_item.end_of_image = tag_ff.end_of_image;
   end

   ppe_out_fifo #(
      .DEPTH(OUT_DEPTH)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (tag_ff.valid),
      .push_item(push_item),
      .count    (fifo_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   // The credit check keeps a read in flight from finding the queue full.
   `PPE_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, tag_ff.valid && (fifo_count == FCW'(OUT_DEPTH)))
   // Palette writes only land once the byte in progress is on its last read.
   `PPE_ASSERT(a_palette_write_interlock, clock, reset, (req_fire && (req_item.opcode == OP_PALETTE_WRITE)) |-> (left_ff <= 4'd1))
   // A byte that arrives with no pixels owed produces no reads.
   `PPE_ASSERT(a_empty_image_idle, clock, reset, (req_fire && (req_item.opcode == OP_PIXEL) && (pixels_left_ff == 24'd0)) |=> (left_ff == 4'd0))
   // Only a start item can raise the remaining pixel count.
   `PPE_ASSERT(a_count_rises_on_start, clock, reset, (pixels_left_ff > $past(pixels_left_ff)) |-> $past(req_fire && (req_item.opcode == OP_START)))

endmodule

// ----- test/palette_checker.sv -----
module palette_checker import ppe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata,
   output int           error_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT;

   // Shadow copy of the palette, the format registers and the pixel counter.
   logic [15:0]  palette [PALETTE_DEPTH];
   logic [1:0]   bpp_mode;
   logic [23:0]  image_len;
   logic [23:0]  pixels_owed;
   rsp_item_type expected_pixels [$];

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   // Prints one line for a bad field and counts it.
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("palette_checker: %s mismatch, got %h expected %h", what, got, want);
      error_count++;
   endtask

   // RGB888 reduced to 5/6/5 bits, stored with the low byte of the word first.
   function automatic logic [15:0] swapped_rgb565(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
      return {g[4:2], b[7:3], r[7:3], g[7:5]};
   endfunction

   // Cuts one pixel byte into fields and queues one word per pixel still owed.
   task automatic expand_byte(input logic [7:0] data);
      int unsigned width;
      int unsigned count;
      int unsigned k;
      logic [7:0]   index;
      rsp_item_type pixel;
      width = 1 << bpp_mode;
      count = 8 >> bpp_mode;
      if (pixels_owed < count) begin
         count = {8'd0, pixels_owed};
      end
      for (k = 0; k < count; k++) begin
         index = (data >> (k * width)) & 8'((1 << width) - 1);
         pixels_owed = pixels_owed - 24'd1;
         pixel.pixel_word = (index >= PALETTE_DEPTH) ? 16'h0000 : palette[index];
         pixel.last_of_byte = (k + 1 == count);
         pixel.end_of_image = (pixels_owed == 24'd0);
         expected_pixels.push_back(pixel);
      end
   endtask

   // Results are checked before new items are predicted; an item accepted
   // at this edge cannot have produced a result yet.
   always @(posedge clock) begin
      if (reset) begin
         bpp_mode = BPP_1;
         image_len = '0;
         pixels_owed = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected item, pixel_word", rsp_item.pixel_word, 'x);
            end else begin
               if (rsp_item.pixel_word !== expected_pixels[0].pixel_word) begin
                  report_mismatch("pixel_word", rsp_item.pixel_word,
                                  expected_pixels[0].pixel_word);
               end
               if (rsp_item.last_of_byte !== expected_pixels[0].last_of_byte) begin
                  report_mismatch("last_of_byte", 16'(rsp_item.last_of_byte),
                                  16'(expected_pixels[0].last_of_byte));
               end
               if (rsp_item.end_of_image !== expected_pixels[0].end_of_image) begin
                  report_mismatch("end_of_image", 16'(rsp_item.end_of_image),
                                  16'(expected_pixels[0].end_of_image));
               end
               void'(expected_pixels.pop_front());
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BPP_LOG2) begin
               bpp_mode = csr_wdata[1:0];
            end else begin
               image_len = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            case (req_item.opcode)
               OP_PALETTE_WRITE: begin
                  if (req_item.entry_index < PALETTE_DEPTH) begin
                     palette[req_item.entry_index] =
                        swapped_rgb565(req_item.red, req_item.green, req_item.blue);
                  end
               end
               OP_START: begin
                  pixels_owed = image_len;
               end
               OP_PIXEL: begin
                  expand_byte(req_item.packed_byte);
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ppe_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int SEGMENTS = 8;
   localparam int SEGMENT_ITEMS = 25;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [23:0]  csr_wdata;
   int           error_count;
   int           pending_count;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   bit          hold_request = 1'b0;
   bit          hold_off;
   bit          entry_written [256];
   logic [1:0]  cur_bpp = BPP_1;
   int unsigned cycle_count = 0;

   palette_pixel_expander_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   palette_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The result side stalls at random, or completely while a hold-off runs.
   always @(posedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // One long hold-off so that the block fills up and stalls its input.
   initial begin
      hold_off = 1'b0;
      wait (hold_request);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Idling modes: none, sender only, receiver only, both lightly.
   task automatic set_idling(input int mode);
      case (mode)
         1:       begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
         3:       begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // Offers one item after a random gap and holds it until it is accepted.
   task automatic send_item(input req_item_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_item <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every queued pixel has come out and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [23:0] data);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sets the pixel format and image length while the block is idle. The
   // upper bits of the format word are sometimes filled with noise.
   task automatic set_format(input logic [1:0] bpp, input logic [23:0] pixels);
      logic [23:0] word;
      word = ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'd0;
      word[1:0] = bpp;
      settle();
      write_reg(CSR_BPP_LOG2, word);
      write_reg(CSR_IMAGE_PIXELS, pixels);
      cur_bpp = bpp;
   endtask

   // Fields that the opcode does not use carry random values.
   function automatic req_item_type random_item(input logic [1:0] opcode);
      req_item_type item;
      item = req_item_type'({$urandom, $urandom});
      item.opcode = opcode;
      return item;
   endfunction

   task automatic write_entry(input logic [7:0] index, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
      req_item_type item;
      item = random_item(OP_PALETTE_WRITE);
      item.entry_index = index;
      item.red = r;
      item.green = g;
      item.blue = b;
      send_item(item);
      entry_written[index] = 1'b1;
   endtask

   task automatic send_pixels(input logic [7:0] data);
      req_item_type item;
      item = random_item(OP_PIXEL);
      item.packed_byte = data;
      send_item(item);
   endtask

   // A palette entry below the limit that has already been written.
   function automatic logic [7:0] pick_entry(input int unsigned limit);
      logic [7:0] index;
      repeat (16) begin
         index = 8'($urandom_range(0, limit - 1));
         if (entry_written[index]) begin
            return index;
         end
      end
      return 8'd0;
   endfunction

   // A pixel byte whose every field points at a written entry.
   function automatic logic [7:0] make_byte();
      int unsigned width;
      int unsigned fields;
      int unsigned k;
      logic [7:0]  data;
      width = 1 << cur_bpp;
      fields = 8 >> cur_bpp;
      data = '0;
      for (k = 0; k < fields; k++) begin
         data = data | (pick_entry(1 << width) << (k * width));
      end
      return data;
   endfunction

   initial begin
      int          seg;
      int          count;
      int          choice;
      logic [1:0]  bpp;
      logic [23:0] len;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BPP_LOG2;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Palette entries at the colour extremes, a few index extremes among them.
      write_entry(8'd0, 8'h00, 8'h00, 8'h00);
      write_entry(8'd1, 8'hFF, 8'hFF, 8'hFF);
      write_entry(8'd2, 8'hF8, 8'h00, 8'h00);
      write_entry(8'd3, 8'h00, 8'hFC, 8'h00);
      write_entry(8'd15, 8'h00, 8'h00, 8'hF8);
      write_entry(8'd128, 8'h07, 8'h03, 8'h07);
      write_entry(8'd255, 8'hA5, 8'h5A, 8'hC3);

      // An unused opcode, then a pixel byte before any image has started.
      send_item(random_item(OP_UNUSED));
      send_pixels(8'h01);

      // One bit per pixel: a full byte, a short last byte, then nothing owed.
      set_format(BPP_1, 24'd11);
      send_item(random_item(OP_START));
      send_pixels(8'hA5);
      send_pixels(8'h5A);
      send_pixels(8'hFF);

      // Two bits per pixel with a restart in the middle of the image.
      set_format(BPP_2, 24'd7);
      send_item(random_item(OP_START));
      send_pixels(8'hE4);
      send_item(random_item(OP_START));
      send_pixels(8'h1B);
      send_pixels(8'hE4);

      // Four bits per pixel, the last byte emitting only one pixel.
      set_format(BPP_4, 24'd3);
      send_item(random_item(OP_START));
      send_pixels(8'hF0);
      send_pixels(8'h0F);

      // Largest image at eight bits, then the format changes mid-image and
      // a zero-length image is started.
      set_format(BPP_8, 24'hFFFFFF);
      send_item(random_item(OP_START));
      send_pixels(8'hFF);
      send_pixels(8'h80);
      set_format(BPP_1, 24'd0);
      send_pixels(8'h01);
      send_item(random_item(OP_START));
      send_pixels(8'h02);

      // Random segments, each with its own format and idling mode. Mostly
      // pixel bytes of images, with palette updates, restarts and noise.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         set_idling(seg % 4);
         case (seg)
            0:       bpp = BPP_1;
            1:       bpp = BPP_8;
            default: bpp = 2'($urandom_range(0, 3));
         endcase
         case (seg)
            3:       len = 24'd1;
            7:       len = 24'hFFFFFF;
            default: len = 24'($urandom_range(1, 48));
         endcase
         set_format(bpp, len);
         if (seg == 4) begin
            hold_request = 1'b1;
         end
         send_item(random_item(OP_START));
         count = 0;
         while (count < SEGMENT_ITEMS) begin
            if (seg == 2 && count == SEGMENT_ITEMS / 2) begin
               settle();
            end
            choice = $urandom_range(0, 99);
            if (choice < 62) begin
               send_pixels(make_byte());
               count++;
            end else if (choice < 80) begin
               write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
               count++;
            end else if (choice < 92) begin
               send_item(random_item(OP_START));
               count++;
            end else begin
               send_item(random_item(OP_UNUSED));
            end
         end
      end

      settle();
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- palette_pixel_expander_top.f -----
+incdir+hw/rtl
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_palette_ram.sv
hw/rtl/ppe_out_fifo.sv
hw/rtl/palette_pixel_expander_top.sv
test/palette_checker.sv
test/testbench.sv
